[rtl/pal_pkg.sv]
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and codes for the positional array list: request and result
// payloads, operation and status codes, fixed field widths.
// ----------------------------------------------------------------------------
package pal_pkg;

	localparam int POS_W   = 7;
	localparam int VALIN_W = 32;
	localparam int IDX_W   = 6;
	localparam int COUNT_W = 7;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_BADPOS   = 3'd2,
		ST_EMPTY    = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef struct packed {
		op_t                       op;
		logic [POS_W-1:0]          position;
		logic signed [VALIN_W-1:0] value;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [IDX_W-1:0]   found_index;
		logic [COUNT_W-1:0] count;
		logic               is_empty;
		logic               is_full;
	} res_t;

endpackage

[rtl/pal_chan_if.sv]
// ----------------------------------------------------------------------------
// pal_chan_if
// Valid/ready channel carrying one item of the given payload type.
// ----------------------------------------------------------------------------
interface pal_chan_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

[rtl/pal_mem.sv]
// ----------------------------------------------------------------------------
// pal_mem
// Simple dual-port list storage: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module pal_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/pal_ctrl.sv]
// ----------------------------------------------------------------------------
// pal_ctrl
// Sequencer for the list: checks each request against the count, then
// streams the shift or the search through the memory, one entry a cycle.
// ----------------------------------------------------------------------------
module pal_ctrl #(
	parameter int DEPTH       = 64,
	parameter int VALUE_WIDTH = 32,
	localparam int AW         = $clog2(DEPTH),
	localparam int CW         = $clog2(DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	pal_chan_if.sink               req,
	output logic                   res_valid,
	output pal_pkg::res_t          res,
	input  logic                   res_take,
	output logic                   mem_we,
	output logic [AW-1:0]          mem_waddr,
	output logic [VALUE_WIDTH-1:0] mem_wdata,
	output logic                   mem_re,
	output logic [AW-1:0]          mem_raddr,
	input  logic [VALUE_WIDTH-1:0] mem_rdata
);

	import pal_pkg::*;

	localparam int XW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RUN  = 4'b0010,
		S_PUT  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          count_q;
	op_t                    op_q;
	logic [POS_W-1:0]       pos_q;
	logic [VALUE_WIDTH-1:0] val_q;
	status_t                status_q;
	logic [IDX_W-1:0]       found_q;
	logic                   rd_go_q;
	logic [AW-1:0]          rd_addr_q;
	logic                   dv_s1;
	logic [AW-1:0]          idx_s1;

	logic                   req_fire;
	logic [XW-1:0]          pos_x;
	logic [XW-1:0]          cnt_x;
	logic [XW-1:0]          lim_x;
	logic                   rd_last;
	logic                   hit;
	logic [2*VALIN_W-1:0]   val_ext;

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign pos_x     = XW'(req.data.position);
	assign cnt_x     = XW'(count_q);
	assign val_ext   = {{VALIN_W{req.data.value[VALIN_W-1]}}, req.data.value};

	// last read: down to the insert position, or up to the final entry
	assign lim_x   = (op_q == OP_INSERT) ? XW'(pos_q) : (XW'(count_q) - XW'(1));
	assign rd_last = (XW'(rd_addr_q) == lim_x);
	assign hit     = (op_q == OP_SEARCH) && dv_s1 && (mem_rdata == val_q);

	assign mem_re    = (state_q == S_RUN) && rd_go_q && !hit;
	assign mem_raddr = rd_addr_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = mem_rdata;
		if (state_q == S_RUN && dv_s1 && op_q == OP_INSERT) begin
			mem_we    = 1'b1;
			mem_waddr = idx_s1 + AW'(1);
		end else if (state_q == S_RUN && dv_s1 && op_q == OP_REMOVE) begin
			mem_we    = 1'b1;
			mem_waddr = idx_s1 - AW'(1);
		end else if (state_q == S_PUT) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(pos_q);
			mem_wdata = val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rd_go_q <= 1'b0;
			dv_s1   <= 1'b0;
		end else begin
			dv_s1 <= mem_re;
			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						unique case (req.data.op)
							OP_INSERT: begin
								if (count_q == CW'(DEPTH)) begin
									state_q <= S_DONE;
								end else if (pos_x > cnt_x) begin
									state_q <= S_DONE;
								end else if (pos_x == cnt_x) begin
									state_q <= S_PUT;
								end else begin
									rd_go_q <= 1'b1;
									state_q <= S_RUN;
								end
							end
							OP_REMOVE: begin
								if (count_q == '0) begin
									state_q <= S_DONE;
								end else if (pos_x >= cnt_x) begin
									state_q <= S_DONE;
								end else if (pos_x == cnt_x - XW'(1)) begin
									// tail entry: nothing to move
									count_q <= count_q - CW'(1);
									state_q <= S_DONE;
								end else begin
									rd_go_q <= 1'b1;
									state_q <= S_RUN;
								end
							end
							OP_SEARCH: begin
								if (count_q == '0) begin
									state_q <= S_DONE;
								end else begin
									rd_go_q <= 1'b1;
									state_q <= S_RUN;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_RUN: begin
					if (hit) begin
						rd_go_q <= 1'b0;
						state_q <= S_DONE;
					end else begin
						if (mem_re && rd_last) begin
							rd_go_q <= 1'b0;
						end
						if (!rd_go_q) begin
							// final read data handled this cycle
							unique case (op_q)
								OP_INSERT: state_q <= S_PUT;
								OP_REMOVE: begin
									count_q <= count_q - CW'(1);
									state_q <= S_DONE;
								end
								default: state_q <= S_DONE;
							endcase
						end
					end
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item payload, addresses and result fields
	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr_q;
		if (req_fire) begin
			op_q    <= req.data.op;
			pos_q   <= req.data.position;
			val_q   <= val_ext[VALUE_WIDTH-1:0];
			found_q <= '0;
			if (req.data.op == OP_INSERT) begin
				rd_addr_q <= AW'(count_q - CW'(1));
			end else if (req.data.op == OP_REMOVE) begin
				rd_addr_q <= AW'(req.data.position) + AW'(1);
			end else begin
				rd_addr_q <= '0;
			end
			priority if (req.data.op == OP_INSERT && count_q == CW'(DEPTH)) begin
				status_q <= ST_FULL;
			end else if (req.data.op == OP_INSERT && pos_x > cnt_x) begin
				status_q <= ST_BADPOS;
			end else if (req.data.op == OP_REMOVE && count_q == '0) begin
				status_q <= ST_EMPTY;
			end else if (req.data.op == OP_REMOVE && pos_x >= cnt_x) begin
				status_q <= ST_BADPOS;
			end else if (req.data.op == OP_SEARCH) begin
				status_q <= ST_NOTFOUND;
			end else begin
				status_q <= ST_OK;
			end
		end else if (state_q == S_RUN && mem_re) begin
			if (op_q == OP_INSERT) begin
				rd_addr_q <= rd_addr_q - AW'(1);
			end else begin
				rd_addr_q <= rd_addr_q + AW'(1);
			end
		end
		if (hit) begin
			status_q <= ST_OK;
			found_q  <= IDX_W'(idx_s1);
		end
	end

	assign res_valid       = (state_q == S_DONE);
	assign res.status      = status_q;
	assign res.found_index = found_q;
	assign res.count       = COUNT_W'(count_q);
	assign res.is_empty    = (count_q == '0);
	assign res.is_full     = (count_q == CW'(DEPTH));

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && mem_re) |-> (mem_waddr != mem_raddr))
		else $error("list store read and written at one address");

	a_read_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> (XW'(mem_raddr) < XW'(count_q)))
		else $error("read beyond the filled part of the list");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
			((count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1))))
		else $error("entry count moved by more than one");

endmodule

[rtl/positional_array_list_unit.sv]
// ----------------------------------------------------------------------------
// positional_array_list_unit
// Ordered list of up to DEPTH values with insert, remove and search by value.
// ----------------------------------------------------------------------------
// The list lives in one simple dual-port memory (one read, one write port,
// registered read data); every request that moves or reads entries walks
// through it one entry a cycle, bound by the single read port. An insert at p
// shifts the entries from the tail down to p up by one, then writes the value
// (an append writes it at once); a remove shifts the entries behind p down by
// one (none for the last entry); a search stops at the first match; errors, a
// search of an empty list and the unused opcode go straight to the result.
// One item is worked on at a time; a new one is taken while the previous
// result waits in the output register.
module positional_array_list_unit #(
	parameter int DEPTH       = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	pal_chan_if.sink   req,
	pal_chan_if.source rsp
);

	import pal_pkg::*;

	localparam int AW = $clog2(DEPTH);

	logic                   res_valid;
	res_t                   res;
	logic                   res_take;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [VALUE_WIDTH-1:0] mem_wdata;
	logic                   mem_re;
	logic [AW-1:0]          mem_raddr;
	logic [VALUE_WIDTH-1:0] mem_rdata;
	logic                   rsp_valid_q;
	res_t                   rsp_data_q;

	pal_ctrl #(
		.DEPTH       (DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	pal_mem #(
		.DEPTH (DEPTH),
		.WIDTH (VALUE_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register: free when empty or being drained
	assign res_take = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			rsp_data_q <= res;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

endmodule
